@@ rtl/core/i2cmbe_pkg.sv @@
// shared types and constants of the i2c master byte engine
`default_nettype none

package i2cmbe_pkg;

    // item kinds
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // bus commands
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    // acknowledge behaviour after a read
    localparam logic [1:0] ACK_MODE_NACK = 2'd0;
    localparam logic [1:0] ACK_MODE_ACK  = 2'd1;

    // sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST1      = 5'd1,
        PH_ST2      = 5'd2,
        PH_SP1      = 5'd3,
        PH_SP2      = 5'd4,
        PH_W_HI     = 5'd5,
        PH_W_LO     = 5'd6,
        PH_W_NX     = 5'd7,
        PH_ACK_UP   = 5'd8,
        PH_ACK_POLL = 5'd9,
        PH_R_LOW    = 5'd10,
        PH_R_HIGH   = 5'd11,
        PH_A_UP     = 5'd12,
        PH_A_DN     = 5'd13
    } phase_t;

    // configuration register indexes and reset values
    localparam int          CfgAddrWidth     = 2;
    localparam logic [0:0]  REG_ACK_TIMEOUT  = 1'd0;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    // input beat
    typedef struct packed {
        logic       kind;
        logic [1:0] command;
        logic [7:0] write_data;
        logic [1:0] ack_mode;
        logic       sda_sample;
    } item_t;

    // result beat
    typedef struct packed {
        logic       scl;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] read_data;
        logic       ack_missing;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/i2cmbe_item_if.sv @@
// valid/ready channel carrying input beats
`default_nettype none

interface i2cmbe_item_if;
    import i2cmbe_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/core/i2cmbe_result_if.sv @@
// valid/ready channel carrying result beats
`default_nettype none

interface i2cmbe_result_if;
    import i2cmbe_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/core/i2c_master_byte_engine.sv @@
// i2c master byte engine: bus sequencer stepped by command and tick beats
// output: each result beat is registered and appears in the cycle after its input beat is taken
// throughput: one input beat per cycle; the only stall is a full result register
// the result register frees as its beat is taken, so input and output overlap
// reset: asynchronous active low; idle with scl and sda driven high, timeout 250
`default_nettype none

module i2c_master_byte_engine (
    input  wire                              clk,
    input  wire                              rst_n,
    i2cmbe_item_if.sink                      item,
    i2cmbe_result_if.source                  result,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [i2cmbe_pkg::CfgAddrWidth-1:0] paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import i2cmbe_pkg::*;

    logic [7:0] ack_timeout_reg;

    phase_t     phase_reg,       phase_next;
    logic [3:0] bit_count_reg,   bit_count_next;
    logic [7:0] shift_data_reg,  shift_data_next;
    logic [7:0] wait_count_reg,  wait_count_next;
    logic [1:0] pending_ack_reg, pending_ack_next;
    logic       scl_reg,         scl_next;
    logic       sda_reg,         sda_next;
    logic       sda_en_reg,      sda_en_next;
    logic       error_reg,       error_next;
    logic [7:0] read_hold_reg,   read_hold_next;
    logic       done_next;

    result_t    result_reg,      result_next;
    logic       result_valid_reg;

    logic       accept;
    logic [3:0] bit_count_inc;
    logic [8:0] wait_count_inc;
    logic [7:0] shift_left;
    logic       cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[CfgAddrWidth-1 -: 1] == REG_ACK_TIMEOUT)
                       ? {24'd0, ack_timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_write && paddr[CfgAddrWidth-1 -: 1] == REG_ACK_TIMEOUT)
        begin
            ack_timeout_reg <= pwdata[7:0];
        end
    end

    // handshake: take a beat whenever the result register is free or draining
    assign item.ready = !result_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign bit_count_inc  = bit_count_reg + 4'd1;
    assign wait_count_inc = {1'b0, wait_count_reg} + 9'd1;
    assign shift_left     = {shift_data_reg[6:0], 1'b0};

    // sequencer next state
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_data_next  = shift_data_reg;
        wait_count_next  = wait_count_reg;
        pending_ack_next = pending_ack_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_en_next      = sda_en_reg;
        error_next       = error_reg;
        read_hold_next   = read_hold_reg;
        done_next        = 1'b0;

        if (item.data.kind == KIND_COMMAND)
        begin
            // commands are dropped while a sequence runs
            if (phase_reg == PH_IDLE)
            begin
                case (command_t'(item.data.command))
                    CMD_START:
                    begin
                        sda_en_next = 1'b1;
                        sda_next    = 1'b1;
                        scl_next    = 1'b1;
                        phase_next  = PH_ST1;
                    end
                    CMD_STOP:
                    begin
                        sda_en_next = 1'b1;
                        scl_next    = 1'b0;
                        sda_next    = 1'b0;
                        phase_next  = PH_SP1;
                    end
                    CMD_WRITE:
                    begin
                        error_next      = 1'b0;
                        bit_count_next  = 4'd0;
                        shift_data_next = item.data.write_data;
                        sda_en_next     = 1'b1;
                        scl_next        = 1'b0;
                        sda_next        = item.data.write_data[7];
                        phase_next      = PH_W_HI;
                    end
                    default:
                    begin
                        pending_ack_next = item.data.ack_mode;
                        bit_count_next   = 4'd0;
                        shift_data_next  = 8'd0;
                        sda_en_next      = 1'b0;
                        scl_next         = 1'b0;
                        phase_next       = PH_R_LOW;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_ST1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST2;
                end
                PH_ST2:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_SP1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_SP2;
                end
                PH_SP2:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_W_HI:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_W_LO;
                end
                PH_W_LO:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_W_NX;
                end
                PH_W_NX:
                begin
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= BITS_PER_BYTE)
                    begin
                        sda_en_next     = 1'b0;
                        wait_count_next = 8'd0;
                        phase_next      = PH_ACK_UP;
                    end
                    else
                    begin
                        shift_data_next = shift_left;
                        sda_next        = shift_left[7];
                        phase_next      = PH_W_HI;
                    end
                end
                PH_ACK_UP:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_ACK_POLL;
                end
                PH_ACK_POLL:
                begin
                    // slave pulls sda low to acknowledge
                    if (!item.data.sda_sample)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (wait_count_inc > {1'b0, ack_timeout_reg})
                    begin
                        error_next  = 1'b1;
                        sda_en_next = 1'b1;
                        scl_next    = 1'b0;
                        sda_next    = 1'b0;
                        phase_next  = PH_SP1;
                    end
                    else
                    begin
                        wait_count_next = wait_count_inc[7:0];
                    end
                end
                PH_R_LOW:
                begin
                    scl_next        = 1'b1;
                    shift_data_next = {shift_data_reg[6:0], item.data.sda_sample};
                    bit_count_next  = bit_count_inc;
                    phase_next      = PH_R_HIGH;
                end
                PH_R_HIGH:
                begin
                    if (bit_count_reg < BITS_PER_BYTE)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_R_LOW;
                    end
                    else
                    begin
                        read_hold_next = shift_data_reg;
                        if (pending_ack_reg == ACK_MODE_NACK
                            || pending_ack_reg == ACK_MODE_ACK)
                        begin
                            scl_next    = 1'b0;
                            sda_en_next = 1'b1;
                            sda_next    = (pending_ack_reg == ACK_MODE_NACK);
                            phase_next  = PH_A_UP;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_A_UP:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_A_DN;
                end
                PH_A_DN:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result beat built from the updated state
    always_comb
    begin
        result_next.scl         = scl_next;
        result_next.sda_level   = sda_en_next ? sda_next : 1'b1;
        result_next.sda_drive   = sda_en_next;
        result_next.read_data   = read_hold_next;
        result_next.ack_missing = error_next;
        result_next.busy_res    = (phase_next != PH_IDLE);
        result_next.done_res    = done_next;
    end

    // sequencer state, updated per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= 4'd0;
            shift_data_reg  <= 8'd0;
            wait_count_reg  <= 8'd0;
            pending_ack_reg <= 2'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_en_reg      <= 1'b1;
            error_reg       <= 1'b0;
            read_hold_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_data_reg  <= shift_data_next;
            wait_count_reg  <= wait_count_next;
            pending_ack_reg <= pending_ack_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_en_reg      <= sda_en_next;
            error_reg       <= error_next;
            read_hold_reg   <= read_hold_next;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

endmodule

`default_nettype wire
